[design/grm_pkg.sv]
// Shared types, constants, microcode ROM and CORDIC angle table for the grid ray marcher.
package grm_pkg;

    localparam int TILE_SIZE    = 32;
    localparam int MAP_DIM      = 64;
    localparam int MAX_STEPS    = 500;
    localparam int ANGLE_STEPS  = 4096;

    localparam int MAP_BITS     = $clog2(MAP_DIM);
    localparam int MAP_DEPTH    = MAP_DIM * MAP_DIM;
    localparam int MAP_AW       = 2 * MAP_BITS;
    localparam int TILE_SHIFT   = $clog2(TILE_SIZE * 256);

    localparam int DIM_W        = 7;
    localparam int BIAS_W       = 14;
    localparam int ORG_W        = 19;
    localparam int HEAD_W       = $clog2(ANGLE_STEPS);
    localparam int PHASE_SHIFT  = 16 - HEAD_W;
    localparam int POS_W        = 20;
    localparam int DELTA_W      = 16;
    localparam int CNT_W        = 9;
    localparam int CELL_MAG_W   = POS_W - TILE_SHIFT;

    localparam int CORDIC_ITERS = 14;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int CX_W         = 20;
    localparam int Z_W          = 18;

    localparam logic signed [CX_W-1:0] CORDIC_GAIN = CX_W'(27858);
    localparam logic signed [CX_W-1:0] ROUND_HALF  = CX_W'(128);
    localparam logic signed [Z_W-1:0]  Z_QUARTER   = Z_W'(16384);
    localparam logic signed [Z_W-1:0]  Z_HALF      = Z_W'(32768);
    localparam logic signed [Z_W-1:0]  Z_THREE_Q   = Z_W'(49152);
    localparam logic signed [Z_W-1:0]  Z_FULL      = Z_W'(65536);

    // configuration register indexes
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_MAP_WIDTH   = 2'd0;
    localparam t_reg_idx REG_MAP_HEIGHT  = 2'd1;
    localparam t_reg_idx REG_ORIGIN_BIAS = 2'd2;

    localparam logic [DIM_W-1:0] MAP_WIDTH_RST  = DIM_W'(64);
    localparam logic [DIM_W-1:0] MAP_HEIGHT_RST = DIM_W'(64);

    typedef enum logic [1:0] {
        RSN_WALL  = 2'd0,
        RSN_LEFT  = 2'd1,
        RSN_LIMIT = 2'd2
    } t_reason;

    typedef enum logic [2:0] {
        DP_IDLE,
        DP_FETCH,
        DP_ROT,
        DP_FIN,
        DP_MARCH,
        DP_EMIT
    } t_dp_op;

    // repeat condition: the word repeats while it holds, else goes to nxt
    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_CAST,
        C_ITER_MORE,
        C_NOT_STOP,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic [2:0] {
        UA_FETCH,
        UA_ROT,
        UA_FIN,
        UA_MARCH,
        UA_EMIT
    } t_uaddr;

    typedef struct packed {
        t_dp_op op;
        t_cond  rpt;
        t_uaddr nxt;
        logic   take;
    } t_uword;

    typedef struct packed {
        t_dp_op op;
        logic   load;
        logic   map_we;
    } t_dp_ctl;

    typedef struct packed {
        logic iter_more;
        logic stop;
        logic out_busy;
    } t_dp_stat;

    typedef struct packed {
        logic [DIM_W-1:0]  map_width;
        logic [DIM_W-1:0]  map_height;
        logic [BIAS_W-1:0] origin_bias;
    } t_cfg;

    function automatic t_uword urom(input t_uaddr a);
        t_uword w;
        unique case (a)
            UA_FETCH: w = '{op: DP_FETCH, rpt: C_NO_CAST,   nxt: UA_ROT,   take: 1'b1};
            UA_ROT:   w = '{op: DP_ROT,   rpt: C_ITER_MORE, nxt: UA_FIN,   take: 1'b0};
            UA_FIN:   w = '{op: DP_FIN,   rpt: C_NEVER,     nxt: UA_MARCH, take: 1'b0};
            UA_MARCH: w = '{op: DP_MARCH, rpt: C_NOT_STOP,  nxt: UA_EMIT,  take: 1'b0};
            UA_EMIT:  w = '{op: DP_EMIT,  rpt: C_OUT_BUSY,  nxt: UA_FETCH, take: 1'b0};
            default:  w = '{op: DP_IDLE,  rpt: C_NEVER,     nxt: UA_FETCH, take: 1'b0};
        endcase
        return w;
    endfunction

    // arctangent of 2^-i in 65536 units per turn
    function automatic logic signed [Z_W-1:0] arc_of(input logic [ITER_W-1:0] i);
        logic signed [Z_W-1:0] a;
        unique case (i)
            4'd0:    a = Z_W'(8192);
            4'd1:    a = Z_W'(4836);
            4'd2:    a = Z_W'(2555);
            4'd3:    a = Z_W'(1297);
            4'd4:    a = Z_W'(651);
            4'd5:    a = Z_W'(326);
            4'd6:    a = Z_W'(163);
            4'd7:    a = Z_W'(81);
            4'd8:    a = Z_W'(41);
            4'd9:    a = Z_W'(20);
            4'd10:   a = Z_W'(10);
            4'd11:   a = Z_W'(5);
            4'd12:   a = Z_W'(3);
            4'd13:   a = Z_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[design/grm_map.sv]
// One-bit wall map memory with one write port and one registered read port.
module grm_map (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [grm_pkg::MAP_AW-1:0] i_waddr,
    input  logic                       i_wdata,
    input  logic [grm_pkg::MAP_AW-1:0] i_raddr,
    output logic                       o_rdata
);
    import grm_pkg::*;

    logic r_mem [MAP_DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/grm_seq.sv]
// Microcode sequencer: step counter, control ROM and repeat-or-branch logic.
module grm_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_command,
    input  grm_pkg::t_dp_stat i_stat,
    output logic              o_ready,
    output grm_pkg::t_dp_ctl  o_ctl
);
    import grm_pkg::*;

    t_uaddr r_upc;
    t_uaddr n_upc;
    t_uword uw;
    logic   hold;

    assign uw = urom(r_upc);

    // control word outputs
    always_comb begin
        o_ready      = uw.take;
        o_ctl.op     = uw.op;
        o_ctl.load   = uw.take && i_valid && i_command;
        o_ctl.map_we = uw.take && i_valid && !i_command;
    end

    // next step: repeat while the condition holds, else branch
    always_comb begin
        unique case (uw.rpt)
            C_NEVER:     hold = 1'b0;
            C_NO_CAST:   hold = !(uw.take && i_valid && i_command);
            C_ITER_MORE: hold = i_stat.iter_more;
            C_NOT_STOP:  hold = !i_stat.stop;
            C_OUT_BUSY:  hold = i_stat.out_busy;
            default:     hold = 1'b0;
        endcase
        n_upc = hold ? r_upc : uw.nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

    a_cast_starts_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> (r_upc == UA_ROT))
        else $error("cast transfer did not start the rotation loop");

    a_write_stays_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.map_we |=> (r_upc == UA_FETCH))
        else $error("map write left the fetch step");

    a_emit_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UA_EMIT && !i_stat.out_busy) |=> (r_upc == UA_FETCH))
        else $error("emit step did not return to fetch");

endmodule

[design/grm_dp.sv]
// Datapath: CORDIC direction unit, march position registers, map lookup, output register.
module grm_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  grm_pkg::t_dp_ctl                  i_ctl,
    input  grm_pkg::t_cfg                     i_cfg,
    input  logic [grm_pkg::MAP_BITS-1:0]      i_cell_x,
    input  logic [grm_pkg::MAP_BITS-1:0]      i_cell_y,
    input  logic                              i_cell_is_wall,
    input  logic [grm_pkg::ORG_W-1:0]         i_origin_x,
    input  logic [grm_pkg::ORG_W-1:0]         i_origin_y,
    input  logic [grm_pkg::HEAD_W-1:0]        i_ray_heading,
    input  logic                              i_ready,
    output grm_pkg::t_dp_stat                 o_stat,
    output logic                              o_valid,
    output logic signed [grm_pkg::POS_W-1:0]  o_end_x,
    output logic signed [grm_pkg::POS_W-1:0]  o_end_y,
    output logic [grm_pkg::CNT_W-1:0]         o_steps_taken,
    output logic [1:0]                        o_stop_reason
);
    import grm_pkg::*;

    logic signed [POS_W-1:0]   r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic signed [DELTA_W-1:0] r_dx, r_dy, n_dx, n_dy;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    t_reason                   r_reason, n_reason;
    logic signed [CX_W-1:0]    r_x, r_y, n_x, n_y;
    logic signed [Z_W-1:0]     r_z, n_z;
    logic [ITER_W-1:0]         r_iter, n_iter;
    logic                      r_flip, n_flip;

    logic                      r_ov, n_ov, out_load;
    logic signed [POS_W-1:0]   r_oend_x, r_oend_y;
    logic [CNT_W-1:0]          r_osteps;
    t_reason                   r_oreason;

    logic signed [Z_W-1:0]     z_a;
    logic                      flip_a;
    logic signed [CX_W-1:0]    sx, sy, xf, yf, rx, ry;
    logic signed [Z_W-1:0]     arc;

    logic [DIM_W-1:0]          lim_w, lim_h;
    logic [CELL_MAG_W-1:0]     mag_x, mag_y, nmag_x, nmag_y;
    logic                      oob, at_limit, wall, stop;
    logic [MAP_AW-1:0]         raddr;

    // truncating cell magnitude: |p| / (TILE_SIZE * 256)
    function automatic logic [CELL_MAG_W-1:0] cell_mag(input logic signed [POS_W-1:0] p);
        logic [POS_W-1:0] m;
        m = p[POS_W-1] ? (~p + 1'b1) : p;
        return m[POS_W-1:TILE_SHIFT];
    endfunction

    grm_map u_map (
        .i_clk   (i_clk),
        .i_we    (i_ctl.map_we),
        .i_waddr ({i_cell_y, i_cell_x}),
        .i_wdata (i_cell_is_wall),
        .i_raddr (raddr),
        .o_rdata (wall)
    );

    // fold the heading into the right half plane
    always_comb begin
        z_a    = Z_W'({i_ray_heading, {PHASE_SHIFT{1'b0}}});
        flip_a = 1'b0;
        if (z_a >= Z_THREE_Q) begin
            z_a = z_a - Z_FULL;
        end
        if (z_a > Z_QUARTER) begin
            z_a    = z_a - Z_HALF;
            flip_a = 1'b1;
        end
    end

    always_comb begin
        sx  = r_x >>> r_iter;
        sy  = r_y >>> r_iter;
        arc = arc_of(r_iter);
        xf  = r_flip ? -r_x : r_x;
        yf  = r_flip ? -r_y : r_y;
        rx  = (xf + ROUND_HALF) >>> 8;
        ry  = (yf + ROUND_HALF) >>> 8;
    end

    // bounds and stop test on the current position
    always_comb begin
        lim_w    = (i_cfg.map_width > DIM_W'(MAP_DIM)) ? DIM_W'(MAP_DIM) : i_cfg.map_width;
        lim_h    = (i_cfg.map_height > DIM_W'(MAP_DIM)) ? DIM_W'(MAP_DIM) : i_cfg.map_height;
        mag_x    = cell_mag(r_pos_x);
        mag_y    = cell_mag(r_pos_y);
        oob      = (r_pos_x[POS_W-1] && mag_x != '0) || (r_pos_y[POS_W-1] && mag_y != '0)
                   || (CELL_MAG_W'(mag_x) >= CELL_MAG_W'(lim_w))
                   || (CELL_MAG_W'(mag_y) >= CELL_MAG_W'(lim_h));
        at_limit = (r_cnt == CNT_W'(MAX_STEPS));
        stop     = at_limit || oob || wall;
    end

    always_comb begin
        n_pos_x  = r_pos_x;
        n_pos_y  = r_pos_y;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_cnt    = r_cnt;
        n_reason = r_reason;
        n_x      = r_x;
        n_y      = r_y;
        n_z      = r_z;
        n_iter   = r_iter;
        n_flip   = r_flip;
        unique case (i_ctl.op)
            DP_FETCH: begin
                if (i_ctl.load) begin
                    n_pos_x = POS_W'(i_origin_x) + POS_W'(i_cfg.origin_bias);
                    n_pos_y = POS_W'(i_origin_y) + POS_W'(i_cfg.origin_bias);
                    n_x     = CORDIC_GAIN;
                    n_y     = '0;
                    n_z     = z_a;
                    n_flip  = flip_a;
                    n_iter  = '0;
                end
            end
            DP_ROT: begin
                if (!r_z[Z_W-1]) begin
                    n_x = r_x - sy;
                    n_y = r_y + sx;
                    n_z = r_z - arc;
                end else begin
                    n_x = r_x + sy;
                    n_y = r_y - sx;
                    n_z = r_z + arc;
                end
                n_iter = r_iter + ITER_W'(1);
            end
            DP_FIN: begin
                n_dx  = DELTA_W'(rx);
                n_dy  = DELTA_W'(ry);
                n_cnt = '0;
            end
            DP_MARCH: begin
                priority if (at_limit) begin
                    n_reason = RSN_LIMIT;
                end else if (oob) begin
                    n_reason = RSN_LEFT;
                end else if (wall) begin
                    n_reason = RSN_WALL;
                end else begin
                    n_pos_x = r_pos_x + POS_W'(r_dx);
                    n_pos_y = r_pos_y + POS_W'(r_dy);
                    n_cnt   = r_cnt + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // look up the cell of the next position so its bit is ready with it
    always_comb begin
        nmag_x = cell_mag(n_pos_x);
        nmag_y = cell_mag(n_pos_y);
        raddr  = {nmag_y[MAP_BITS-1:0], nmag_x[MAP_BITS-1:0]};
    end

    always_comb begin
        out_load = (i_ctl.op == DP_EMIT) && !(r_ov && !i_ready);
        if (out_load) begin
            n_ov = 1'b1;
        end else if (i_ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_iter <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_iter <= n_iter;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_x  <= n_pos_x;
        r_pos_y  <= n_pos_y;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_reason <= n_reason;
        r_x      <= n_x;
        r_y      <= n_y;
        r_z      <= n_z;
        r_flip   <= n_flip;
        if (out_load) begin
            r_oend_x  <= r_pos_x;
            r_oend_y  <= r_pos_y;
            r_osteps  <= r_cnt;
            r_oreason <= r_reason;
        end
    end

    assign o_stat.iter_more = (r_iter != ITER_W'(CORDIC_ITERS - 1));
    assign o_stat.stop      = stop;
    assign o_stat.out_busy  = r_ov && !i_ready;
    assign o_valid          = r_ov;
    assign o_end_x          = r_oend_x;
    assign o_end_y          = r_oend_y;
    assign o_steps_taken    = r_osteps;
    assign o_stop_reason    = r_oreason;

    a_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_STEPS))
        else $error("step count beyond the step limit");

    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oreason == RSN_LIMIT) |-> (r_osteps == CNT_W'(MAX_STEPS)))
        else $error("step limit result without full step count");

    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == DP_ROT) |-> (r_iter < ITER_W'(CORDIC_ITERS)))
        else $error("CORDIC iteration index out of range");

endmodule

[design/grid_ray_march.sv]
// Top level of the grid ray marcher: configuration registers, sequencer and datapath.
//
// Input channel (i_valid / o_ready): one transfer per command. A map write
// (i_command 0) stores i_cell_is_wall at (i_cell_x, i_cell_y) in the transfer
// cycle and yields no result. A cast (i_command 1) yields one result on the
// output channel (o_valid / i_ready).
// A cast runs the CORDIC rotation loop, rounds the step vector, then marches,
// each pass testing the current position for a stop and, if none, stepping. It
// then loads the output register, which raises o_valid, and only then returns
// to the fetch step for a new command. The march loop does one map lookup per
// cycle; the wall bit of the next position is read while the current one is
// tested. After a map write the sequencer stays in its fetch step.
// The output register holds one result; while the receiver stalls it holds,
// the sequencer waits in its emit step, and a new command is taken as soon as
// the result is loaded. Reset clears the sequencer, the output valid and the
// registers (map width and height 64, origin bias 0). The wall map is not
// cleared: write every cell that a ray may reach before casting.
// Configuration (APB, pready tied high) must be written by the user only while
// the block is idle; the block itself does not enforce this.
module grid_ray_march (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [3:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_command,
    input  logic [grm_pkg::MAP_BITS-1:0]     i_cell_x,
    input  logic [grm_pkg::MAP_BITS-1:0]     i_cell_y,
    input  logic                             i_cell_is_wall,
    input  logic [grm_pkg::ORG_W-1:0]        i_origin_x,
    input  logic [grm_pkg::ORG_W-1:0]        i_origin_y,
    input  logic [grm_pkg::HEAD_W-1:0]       i_ray_heading,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [grm_pkg::POS_W-1:0] o_end_x,
    output logic signed [grm_pkg::POS_W-1:0] o_end_y,
    output logic [grm_pkg::CNT_W-1:0]        o_steps_taken,
    output logic [1:0]                       o_stop_reason
);
    import grm_pkg::*;

    logic [DIM_W-1:0]  r_map_width;
    logic [DIM_W-1:0]  r_map_height;
    logic [BIAS_W-1:0] r_origin_bias;
    logic              cfg_we;
    t_reg_idx          cfg_idx;
    t_cfg              cfg;
    t_dp_ctl           ctl;
    t_dp_stat          stat;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width   <= MAP_WIDTH_RST;
            r_map_height  <= MAP_HEIGHT_RST;
            r_origin_bias <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_MAP_WIDTH:   r_map_width   <= pwdata[DIM_W-1:0];
                REG_MAP_HEIGHT:  r_map_height  <= pwdata[DIM_W-1:0];
                REG_ORIGIN_BIAS: r_origin_bias <= pwdata[BIAS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MAP_WIDTH:   prdata = 32'(r_map_width);
            REG_MAP_HEIGHT:  prdata = 32'(r_map_height);
            REG_ORIGIN_BIAS: prdata = 32'(r_origin_bias);
            default:         prdata = '0;
        endcase
    end

    assign cfg.map_width   = r_map_width;
    assign cfg.map_height  = r_map_height;
    assign cfg.origin_bias = r_origin_bias;

    grm_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_stat    (stat),
        .o_ready   (o_ready),
        .o_ctl     (ctl)
    );

    grm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_cfg          (cfg),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_cell_is_wall (i_cell_is_wall),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_ray_heading  (i_ray_heading),
        .i_ready        (i_ready),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_end_x        (o_end_x),
        .o_end_y        (o_end_y),
        .o_steps_taken  (o_steps_taken),
        .o_stop_reason  (o_stop_reason)
    );

endmodule

[test/testbench.sv]
// Testbench for grid_ray_march: map writes and ray casts checked against a built-in predictor.
`timescale 1ns / 1ps

module testbench;
    import grm_pkg::*;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_CAST    = 1'b1;
    localparam int   TILE_Q8     = TILE_SIZE * 256;
    localparam int   ORG_MAX     = (1 << ORG_W) - 1;
    localparam int   HOLD_CYCLES = 1500;
    localparam int   QUIET_LIMIT = 20000;
    localparam int   IDLE_GAP    = 32;
    localparam int   END_WAIT    = 600;
    localparam int   ITEM_TARGET = 650;
    localparam int   PHASES      = 8;

    typedef enum {RX_OPEN, RX_COIN, RX_MASK, RX_SPARSE} t_rx_mode;

    typedef struct {
        logic                command;
        logic [MAP_BITS-1:0] cell_x;
        logic [MAP_BITS-1:0] cell_y;
        logic                cell_is_wall;
        logic [ORG_W-1:0]    origin_x;
        logic [ORG_W-1:0]    origin_y;
        logic [HEAD_W-1:0]   heading;
    } t_ray_cmd;

    typedef struct {
        logic signed [POS_W-1:0] end_x;
        logic signed [POS_W-1:0] end_y;
        logic [CNT_W-1:0]        steps;
        t_reason                 reason;
    } t_ray_end;

    // arctangent of 2^-i, 65536 units per turn
    localparam int ARC_Q16 [CORDIC_ITERS] = '{8192, 4836, 2555, 1297, 651, 326, 163,
                                             81, 41, 20, 10, 5, 3, 1};

    class march_checker;
        bit       wall_bit [MAP_DEPTH];
        bit       cell_set [MAP_DEPTH];
        int       map_w = 64;
        int       map_h = 64;
        int       bias  = 0;
        t_ray_end ends_due [$];
        int       errors = 0;

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_MAP_WIDTH:   map_w = int'(value[DIM_W-1:0]);
                REG_MAP_HEIGHT:  map_h = int'(value[DIM_W-1:0]);
                REG_ORIGIN_BIAS: bias  = int'(value[BIAS_W-1:0]);
                default: ;
            endcase
        endfunction

        function int wrap_pos(int v);
            logic signed [POS_W-1:0] m;
            m = v[POS_W-1:0];
            return int'(m);
        endfunction

        // 0.7 pixel step vector in Q8 from a CORDIC rotation
        function void aim(logic [HEAD_W-1:0] heading, output int dx, output int dy);
            int z, x, y, sx, sy;
            bit flip;
            z = (int'(heading) * 65536) / ANGLE_STEPS;
            flip = 1'b0;
            x = 27858;
            y = 0;
            if (z >= 49152) z -= 65536;
            if (z > 16384) begin
                z -= 32768;
                flip = 1'b1;
            end
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                sx = x >>> i;
                sy = y >>> i;
                if (z >= 0) begin
                    x -= sy;
                    y += sx;
                    z -= ARC_Q16[i];
                end else begin
                    x += sy;
                    y -= sx;
                    z += ARC_Q16[i];
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            dx = (x + 128) >>> 8;
            dy = (y + 128) >>> 8;
        endfunction

        // missing returns the first unwritten cell the ray would read, else -1
        function t_ray_end march(t_ray_cmd c, output int missing);
            t_ray_end r;
            int w, h, px, py, dx, dy, cx, cy, idx, n;
            w = (map_w < MAP_DIM) ? map_w : MAP_DIM;
            h = (map_h < MAP_DIM) ? map_h : MAP_DIM;
            px = wrap_pos(int'(c.origin_x) + bias);
            py = wrap_pos(int'(c.origin_y) + bias);
            aim(c.heading, dx, dy);
            missing = -1;
            r.reason = RSN_LIMIT;
            n = 0;
            while (n < MAX_STEPS) begin
                // int division truncates toward zero, as the cell index does
                cx = px / TILE_Q8;
                cy = py / TILE_Q8;
                if (cx < 0 || cy < 0 || cx >= w || cy >= h) begin
                    r.reason = RSN_LEFT;
                    break;
                end
                idx = cy * MAP_DIM + cx;
                if (!cell_set[idx]) begin
                    missing = idx;
                    break;
                end
                if (wall_bit[idx]) begin
                    r.reason = RSN_WALL;
                    break;
                end
                px = wrap_pos(px + dx);
                py = wrap_pos(py + dy);
                n++;
            end
            r.end_x = px[POS_W-1:0];
            r.end_y = py[POS_W-1:0];
            r.steps = n[CNT_W-1:0];
            return r;
        endfunction

        function void note_cmd(t_ray_cmd c);
            int idx, missing;
            if (c.command == CMD_WRITE) begin
                idx = int'(c.cell_y) * MAP_DIM + int'(c.cell_x);
                wall_bit[idx] = c.cell_is_wall;
                cell_set[idx] = 1'b1;
            end else begin
                ends_due.push_back(march(c, missing));
            end
        endfunction

        function void check_end(t_ray_end got);
            t_ray_end want;
            if (ends_due.size() == 0) begin
                $error("result with no cast pending: end_x %0d end_y %0d steps %0d",
                       got.end_x, got.end_y, got.steps);
                errors++;
                return;
            end
            want = ends_due.pop_front();
            if (got.end_x !== want.end_x) begin
                $error("end_x: expected %0d, got %0d", want.end_x, got.end_x);
                errors++;
            end
            if (got.end_y !== want.end_y) begin
                $error("end_y: expected %0d, got %0d", want.end_y, got.end_y);
                errors++;
            end
            if (got.steps !== want.steps) begin
                $error("steps_taken: expected %0d, got %0d", want.steps, got.steps);
                errors++;
            end
            if (got.reason !== want.reason) begin
                $error("stop_reason: expected %0d, got %0d", want.reason, got.reason);
                errors++;
            end
        endfunction

        function int outstanding();
            return ends_due.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [3:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic                    i_command = 1'b0;
    logic [MAP_BITS-1:0]     i_cell_x = '0;
    logic [MAP_BITS-1:0]     i_cell_y = '0;
    logic                    i_cell_is_wall = 1'b0;
    logic [ORG_W-1:0]        i_origin_x = '0;
    logic [ORG_W-1:0]        i_origin_y = '0;
    logic [HEAD_W-1:0]       i_ray_heading = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic signed [POS_W-1:0] o_end_x;
    logic signed [POS_W-1:0] o_end_y;
    logic [CNT_W-1:0]        o_steps_taken;
    logic [1:0]              o_stop_reason;

    march_checker sb = new;
    bit           hold_req = 1'b0;
    int           cmds_sent = 0;
    int           burst_left = 0;
    int           quiet_cycles = 0;

    grid_ray_march i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_cell_is_wall (i_cell_is_wall),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_ray_heading  (i_ray_heading),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_end_x        (o_end_x),
        .o_end_y        (o_end_y),
        .o_steps_taken  (o_steps_taken),
        .o_stop_reason  (o_stop_reason)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_ray_end got;
        if (i_rst_n && o_valid && i_ready) begin
            got.end_x  = o_end_x;
            got.end_y  = o_end_y;
            got.steps  = o_steps_taken;
            got.reason = t_reason'(o_stop_reason);
            sb.check_end(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: stall on a pattern of its own, plus one long hold-off on request
    initial begin
        t_rx_mode   mode;
        int         left;
        logic [7:0] mask;
        mode = RX_OPEN;
        left = 0;
        mask = 8'hff;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = t_rx_mode'($urandom_range(3));
                    left = $urandom_range(32, 256);
                    mask = 8'($urandom) | 8'h01;
                end
                left--;
                case (mode)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_COIN:   i_ready <= 1'($urandom_range(1));
                    RX_MASK: begin
                        i_ready <= mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                    default:   i_ready <= ($urandom_range(3) == 0);
                endcase
            end
        end
    end

    task automatic send_cmd(t_ray_cmd c);
        i_valid        <= 1'b1;
        i_command      <= c.command;
        i_cell_x       <= c.cell_x;
        i_cell_y       <= c.cell_y;
        i_cell_is_wall <= c.cell_is_wall;
        i_origin_x     <= c.origin_x;
        i_origin_y     <= c.origin_y;
        i_ray_heading  <= c.heading;
        do @(posedge i_clk); while (!o_ready);
        sb.note_cmd(c);
        cmds_sent++;
    endtask

    // bursts of random length with random gaps between them
    task automatic offer(t_ray_cmd c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_cmd(c);
    endtask

    function automatic t_ray_cmd write_cmd(int idx, bit wall);
        t_ray_cmd c;
        c.command      = CMD_WRITE;
        c.cell_x       = MAP_BITS'(idx % MAP_DIM);
        c.cell_y       = MAP_BITS'(idx / MAP_DIM);
        c.cell_is_wall = wall;
        c.origin_x     = ORG_W'($urandom);
        c.origin_y     = ORG_W'($urandom);
        c.heading      = HEAD_W'($urandom);
        return c;
    endfunction

    // write every cell the ray would read first, then cast it
    task automatic cast_ray(int ox, int oy, int hd, int wall_pct);
        t_ray_cmd c;
        int       missing;
        c.command      = CMD_CAST;
        c.cell_x       = MAP_BITS'($urandom);
        c.cell_y       = MAP_BITS'($urandom);
        c.cell_is_wall = 1'($urandom);
        c.origin_x     = ORG_W'(ox);
        c.origin_y     = ORG_W'(oy);
        c.heading      = HEAD_W'(hd);
        do begin
            void'(sb.march(c, missing));
            if (missing >= 0)
                offer(write_cmd(missing, int'($urandom_range(99)) < wall_pct));
        end while (missing >= 0);
        offer(c);
    endtask

    // hold the input until every result is back, then let the block go idle
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, value);
    endtask

    // drop the bus after the last access
    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(int w, int h, int b);
        apb_write(REG_MAP_WIDTH, w);
        apb_write(REG_MAP_HEIGHT, h);
        apb_write(REG_ORIGIN_BIAS, b);
        apb_idle();
    endtask

    function automatic int pick_origin(int extent);
        int eff;
        eff = (extent < MAP_DIM) ? extent : MAP_DIM;
        if (eff == 0 || $urandom_range(4) == 0)
            return $urandom_range(ORG_MAX);
        return $urandom_range(eff * TILE_Q8 - 1);
    endfunction

    // quadrant boundaries now and then, where the CORDIC folds the angle
    function automatic int pick_heading();
        int edges [9] = '{0, 1023, 1024, 1025, 2047, 2048, 3071, 3072, 4095};
        if ($urandom_range(7) == 0)
            return edges[$urandom_range(8)];
        return $urandom_range(ANGLE_STEPS - 1);
    endfunction

    initial begin
        int ph_w   [PHASES] = '{64, 127, 0, 1, 64, 23, 65, 40};
        int ph_h   [PHASES] = '{64, 127, 64, 1, 0, 57, 40, 64};
        int ph_b   [PHASES] = '{0, 16383, 300, 0, 8191, 4096, 1234, 0};
        int ph_pct [PHASES] = '{25, 10, 20, 30, 20, 0, 50, 15};
        int quad   [6]      = '{1023, 1024, 1025, 2047, 3071, 3072};
        int phase_end, mid;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_config(64, 64, 0);

        // open row: runs into the step limit
        cast_ray(20 * TILE_Q8 + TILE_Q8 / 2, 20 * TILE_Q8 + TILE_Q8 / 2, 0, 0);
        offer(write_cmd(0, 1'b0));
        offer(write_cmd(MAP_DEPTH - 1, 1'b1));
        // starts on a wall: zero steps
        cast_ray(63 * TILE_Q8 + 100, 63 * TILE_Q8 + 100, 4095, 0);
        // heads west through negative x that still truncates to column zero
        cast_ray(0, 0, 2048, 0);
        // steps past the top of the signed position range and wraps
        cast_ray(ORG_MAX, 3 * TILE_Q8, 0, 0);
        foreach (quad[k])
            cast_ray($urandom_range(ORG_MAX), $urandom_range(ORG_MAX), quad[k], 30);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p == PHASES - 1) begin
                ph_w[p] = $urandom_range(1, 127);
                ph_h[p] = $urandom_range(1, 127);
                ph_b[p] = $urandom_range(16383);
            end
            set_config(ph_w[p], ph_h[p], ph_b[p]);
            phase_end = cmds_sent + (ITEM_TARGET - cmds_sent) / (PHASES - p);
            mid = (cmds_sent + phase_end) / 2;
            // origin corners; with a bias the top corner overflows and wraps negative
            cast_ray(ORG_MAX, ORG_MAX, pick_heading(), ph_pct[p]);
            cast_ray(0, 0, pick_heading(), ph_pct[p]);
            while (cmds_sent < phase_end) begin
                if (cmds_sent >= mid && mid > 0) begin
                    if (p == 2) hold_req = 1'b1;
                    if (p == 4) settle();
                    mid = 0;
                end
                if ($urandom_range(99) < 20)
                    offer(write_cmd($urandom_range(MAP_DEPTH - 1),
                                    int'($urandom_range(99)) < ph_pct[p]));
                else
                    cast_ray(pick_origin(ph_w[p]), pick_origin(ph_h[p]), pick_heading(),
                             ph_pct[p]);
            end
        end

        settle();
        repeat (END_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
